// ----- sv/e2q_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants
// Phase scale factors, CORDIC arctangent table and lane result type for the
// Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

	// Radian scale floor(2^41/pi) and degree scale round(2^45/45).
	localparam logic [39:0] K_RAD = 40'hA2F9836E4E;
	localparam logic [39:0] K_DEG = 40'd781874935307;

	// CORDIC start vector: inverse of the limit gain in Q30.
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	// Saturation bound of a Q1.14 component.
	localparam logic signed [18:0] Q14_ONE = 19'sd16384;

	// Width of the CORDIC datapath and of a lane result.
	localparam int CW = 34;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [29:0] ATAN_TURNS [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd1, 30'd0
	};

	// Cosine and sine of one half angle, Q30.
	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} sincos_t;

endpackage
`default_nettype wire

// ----- sv/euler_to_quaternion_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_top: Z-Y-X Euler angles to unit quaternion
// Three angle lanes feed a merge stage that forms the quaternion.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    roll_angle, pitch_angle, yaw_angle
//   out      output     out_valid/out_stall  quat_i, quat_j, quat_k, quat_w
//   cfg      input      cfg_wen              cfg_wdata (angle_in_degrees)
//
// One transaction is accepted per cycle while the output does not stall; the
// pipeline is made of the two scaling stages, the CORDIC rotation pipeline, the
// quadrant stage and three merge stages. Each stage holds a valid bit and loads
// when it is empty or its successor moves, so a stalled output fills bubbles
// before input stalls. Reset clears valid bits and the mode register (radians).
// ----------------------------------------------------------------------------
module euler_to_quaternion_top import e2q_pkg::*; #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] roll_angle,
	input  wire logic signed [23:0] pitch_angle,
	input  wire logic signed [23:0] yaw_angle,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      quat_i,
	output logic signed [15:0]      quat_j,
	output logic signed [15:0]      quat_k,
	output logic signed [15:0]      quat_w
);

	localparam int LS = CORDIC_STEPS + 3;
	localparam int D  = LS + 3;

	logic         deg_q;
	logic [D-1:0] v_q;
	logic [D:0]   rdy;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (cfg_wen) begin
			deg_q <= cfg_wdata;
		end
	end

	// Per-stage ready chain.
	assign rdy[D] = !out_stall;
	for (genvar k = 0; k < D; k++) begin : g_rdy
		assign rdy[k] = !v_q[k] || rdy[k+1];
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < D; k++) begin
				if (rdy[k]) begin
					v_q[k] <= (k == 0) ? in_valid : v_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = v_q[D-1];

	sincos_t sc_yaw, sc_pitch, sc_roll;

	// Angle lanes.
	e2q_lane #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
		.clk(clk), .en(rdy[LS-1:0]), .deg(deg_q), .angle(yaw_angle), .sc(sc_yaw)
	);
	e2q_lane #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
		.clk(clk), .en(rdy[LS-1:0]), .deg(deg_q), .angle(pitch_angle), .sc(sc_pitch)
	);
	e2q_lane #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
		.clk(clk), .en(rdy[LS-1:0]), .deg(deg_q), .angle(roll_angle), .sc(sc_roll)
	);

	// Quaternion assembly.
	e2q_merge u_merge (
		.clk(clk), .en(rdy[D-1:LS]), .yaw(sc_yaw), .pitch(sc_pitch), .roll(sc_roll),
		.quat_i(quat_i), .quat_j(quat_j), .quat_k(quat_k), .quat_w(quat_w)
	);

	// Input stalls only when the first stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_q[0])
		else $error("input stalled with empty first stage");

	// A stalled result is not dropped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result lost");

	// Components w and i stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384 &&
		               quat_i <= 16'sd16384 && quat_i >= -16'sd16384))
		else $error("quaternion component out of range");

endmodule
`default_nettype wire

// ----- sv/e2q_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_lane: half-angle sine and cosine of one Euler angle
// Scales the angle to a 32-bit half-turn phase, then runs a fully pipelined
// CORDIC on the residual and applies the quadrant by swap and negate.
// ----------------------------------------------------------------------------
module e2q_lane import e2q_pkg::*; #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  wire logic                      clk,
	input  wire logic [CORDIC_STEPS+2:0]   en,
	input  wire logic                      deg,
	input  wire logic signed [23:0]        angle,
	output sincos_t                        sc
);

	localparam int SH_RAD = 11 + ANGLE_FRAC_BITS;
	localparam int SH_DEG = 17 + ANGLE_FRAC_BITS;
	localparam int LAST   = CORDIC_STEPS + 2;

	logic signed [44:0] phi_s1, plo_s1;
	logic               deg_s1;
	logic [31:0]        phase_s2;

	logic signed [65:0] psum;
	logic signed [65:0] prad, pdeg;
	logic [39:0]        kmul;

	// Stage 1: two partial products of the angle and the scale factor.
	assign kmul = deg ? K_DEG : K_RAD;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			phi_s1 <= angle * $signed({1'b0, kmul[39:20]});
			plo_s1 <= angle * $signed({1'b0, kmul[19:0]});
			deg_s1 <= deg;
		end
	end

	// Stage 2: combine, round and wrap to a 32-bit phase.
	assign psum = (66'(phi_s1) <<< 20) + 66'(plo_s1);
	assign prad = (psum + (66'sd1 <<< (SH_RAD - 1))) >>> SH_RAD;
	assign pdeg = (psum + (66'sd1 <<< (SH_DEG - 1))) >>> SH_DEG;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			phase_s2 <= deg_s1 ? pdeg[31:0] : prad[31:0];
		end
	end

	// Quadrant is the nearest quarter turn; the residual lies within 1/8 turn.
	logic [31:0] qsum, resid;
	logic [1:0]  quad0;
	assign qsum  = phase_s2 + 32'h2000_0000;
	assign quad0 = qsum[31:30];
	assign resid = phase_s2 - {quad0, 30'd0};

	logic signed [CW-1:0] x_q [CORDIC_STEPS];
	logic signed [CW-1:0] y_q [CORDIC_STEPS];
	logic signed [CW-1:0] z_q [CORDIC_STEPS];
	logic [1:0]           quad_q [CORDIC_STEPS];

	// CORDIC rotation stages, one per register.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [CW-1:0] xi, yi, zi;
		logic [1:0]           qi;
		logic signed [CW-1:0] at;
		if (i == 0) begin : g_first
			assign xi = CORDIC_X0;
			assign yi = '0;
			assign zi = CW'($signed(resid));
			assign qi = quad0;
		end else begin : g_next
			assign xi = x_q[i-1];
			assign yi = y_q[i-1];
			assign zi = z_q[i-1];
			assign qi = quad_q[i-1];
		end
		assign at = CW'($signed({1'b0, ATAN_TURNS[i]}));
		always_ff @(posedge clk) begin
			if (en[i+2]) begin
				if (!zi[CW-1]) begin
					x_q[i] <= xi - (yi >>> i);
					y_q[i] <= yi + (xi >>> i);
					z_q[i] <= zi - at;
				end else begin
					x_q[i] <= xi + (yi >>> i);
					y_q[i] <= yi - (xi >>> i);
					z_q[i] <= zi + at;
				end
				quad_q[i] <= qi;
			end
		end
	end

	// Final stage: rotate the result back by the quadrant.
	logic signed [CW-1:0] xf, yf;
	logic [1:0]           qf;
	assign xf = x_q[CORDIC_STEPS-1];
	assign yf = y_q[CORDIC_STEPS-1];
	assign qf = quad_q[CORDIC_STEPS-1];
	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			case (qf)
				2'd0:    begin sc.c <= xf;  sc.s <= yf;  end
				2'd1:    begin sc.c <= -yf; sc.s <= xf;  end
				2'd2:    begin sc.c <= -xf; sc.s <= -yf; end
				default: begin sc.c <= yf;  sc.s <= -xf; end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/e2q_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_merge: quaternion assembly
// Combines the three lanes' half-angle sines and cosines into i, j, k, w,
// rounds to Q1.14 and saturates.
// ----------------------------------------------------------------------------
module e2q_merge import e2q_pkg::*; (
	input  wire logic               clk,
	input  wire logic [2:0]         en,
	input  wire sincos_t            yaw,
	input  wire sincos_t            pitch,
	input  wire sincos_t            roll,
	output logic signed [15:0]      quat_i,
	output logic signed [15:0]      quat_j,
	output logic signed [15:0]      quat_k,
	output logic signed [15:0]      quat_w
);

	// Q30 product with round half up.
	function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
	                                              input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = (a * b + (68'sd1 <<< 29)) >>> 30;
		return p[CW-1:0];
	endfunction

	// Round Q30 sum to Q1.14 and clamp to plus or minus one.
	function automatic logic signed [15:0] toq14(input logic signed [CW:0] v);
		logic signed [CW:0] r;
		r = (v + (35'sd1 <<< 15)) >>> 16;
		if (r > 35'(Q14_ONE)) begin
			r = 35'(Q14_ONE);
		end else if (r < -35'(Q14_ONE)) begin
			r = -35'(Q14_ONE);
		end
		return r[15:0];
	endfunction

	logic signed [CW-1:0] c1c2_s1, s1s2_s1, c1s2_s1, s1c2_s1, c3_s1, s3_s1;
	logic signed [CW-1:0] a_s2 [8];

	// First products of yaw and pitch terms.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			c1c2_s1 <= mulq(yaw.c, pitch.c);
			s1s2_s1 <= mulq(yaw.s, pitch.s);
			c1s2_s1 <= mulq(yaw.c, pitch.s);
			s1c2_s1 <= mulq(yaw.s, pitch.c);
			c3_s1   <= roll.c;
			s3_s1   <= roll.s;
		end
	end

	// Second products with the roll terms.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s2[0] <= mulq(c1c2_s1, s3_s1);
			a_s2[1] <= mulq(s1s2_s1, c3_s1);
			a_s2[2] <= mulq(c1s2_s1, c3_s1);
			a_s2[3] <= mulq(s1c2_s1, s3_s1);
			a_s2[4] <= mulq(s1c2_s1, c3_s1);
			a_s2[5] <= mulq(c1s2_s1, s3_s1);
			a_s2[6] <= mulq(c1c2_s1, c3_s1);
			a_s2[7] <= mulq(s1s2_s1, s3_s1);
		end
	end

	// Sums, rounding and saturation into the output register.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			quat_i <= toq14(35'(a_s2[0]) - 35'(a_s2[1]));
			quat_j <= toq14(35'(a_s2[2]) + 35'(a_s2[3]));
			quat_k <= toq14(35'(a_s2[4]) - 35'(a_s2[5]));
			quat_w <= toq14(35'(a_s2[6]) + 35'(a_s2[7]));
		end
	end

endmodule
`default_nettype wire
